// File: hdl/csop_pkg.sv
// Shared types, register indexes and the control store of the outline point generator.
package csop_pkg;

  // Width of the micro program counter; it addresses eight control words.
  localparam int UPC_W = 3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SHAPE_KIND    = 3'd0;
  localparam logic [2:0] REG_SHAPE_SIZE    = 3'd1;
  localparam logic [2:0] REG_CENTER_X      = 3'd2;
  localparam logic [2:0] REG_CENTER_Y      = 3'd3;
  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd4;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd5;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath operation selected by one control word.
  typedef enum logic [2:0] {
    OP_ACCEPT,  // take a request and set up the walk offset
    OP_CHECK,   // range check and radicand load
    OP_ROOT,    // one digit of the square root
    OP_PREP,    // floor, exactness and anchor coordinates
    OP_EMIT     // present one point
  } op_t;

  // Jump condition; when it holds the sequencer jumps, else it steps on.
  typedef enum logic [2:0] {
    CND_NEXT,   // never jump
    CND_NO_IN,  // no request taken this cycle
    CND_SKIP,   // not walking or offset outside the shape
    CND_MORE,   // root digits remain
    CND_NO_OUT  // point not yet taken
  } cond_t;

  typedef struct packed {
    logic       in_rdy;
    logic       out_vld;
    logic [1:0] pt;
    op_t        op;
    cond_t      cond;
    upc_t       target;
  } uword_t;

  // Control store. The step after the last one wraps back to the first.
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    w = '{in_rdy: 1'b0, out_vld: 1'b0, pt: 2'd0, op: OP_ACCEPT,
          cond: CND_NEXT, target: upc_t'(0)};
    unique case (addr)
      3'd0: w = '{1'b1, 1'b0, 2'd0, OP_ACCEPT, CND_NO_IN,  upc_t'(0)};
      3'd1: w = '{1'b0, 1'b0, 2'd0, OP_CHECK,  CND_SKIP,   upc_t'(0)};
      3'd2: w = '{1'b0, 1'b0, 2'd0, OP_ROOT,   CND_MORE,   upc_t'(2)};
      3'd3: w = '{1'b0, 1'b0, 2'd0, OP_PREP,   CND_NEXT,   upc_t'(0)};
      3'd4: w = '{1'b0, 1'b1, 2'd0, OP_EMIT,   CND_NO_OUT, upc_t'(4)};
      3'd5: w = '{1'b0, 1'b1, 2'd1, OP_EMIT,   CND_NO_OUT, upc_t'(5)};
      3'd6: w = '{1'b0, 1'b1, 2'd2, OP_EMIT,   CND_NO_OUT, upc_t'(6)};
      3'd7: w = '{1'b0, 1'b1, 2'd3, OP_EMIT,   CND_NO_OUT, upc_t'(7)};
      default: w = '{1'b0, 1'b0, 2'd0, OP_ACCEPT, CND_NEXT, upc_t'(0)};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/circle_square_outline_points.sv
// Outline point generator for one circle or square, driven by a small microprogram.
//
// Usage: configure shape, size, center and canvas over the cfg_ write channel while
// the block is idle. Each request on the in_ channel (tdata bit 0 = restart) handles
// one offset f of the walk from -k to +k and returns four points on the out_ channel
// in a fixed order; tlast marks the fourth point, tuser carries on_canvas and
// walk_done. A restart begins the walk at -k; an advance while no walk is running,
// or with an offset outside the current shape, returns nothing.
// Steps: a request is taken, the offset is checked, the square root is formed digit
// by digit, the anchors are formed and then the four points are presented in turn.
// Stalls: each point is held on out_tdata until out_tready; the sequencer waits and
// takes no new request until the fourth point is taken.
// Reset: registers return to circle, size 0, center 0, canvas 64 by 32; the walk
// is idle and the sequencer waits for a request.
module circle_square_outline_points #(
  parameter int SIZE_BITS  = 8,
  parameter int COORD_BITS = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)-1:0] cfg_data,
  // Request channel. tdata: restart (bit 0), zero fill.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  // Result channel. tdata: pixel_column, pixel_row, zero fill.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [((2 * COORD_BITS + 9) / 8) * 8 - 1:0] out_tdata,
  output logic                   out_tlast,   // last_of_step
  output logic [1:0]             out_tuser    // on_canvas, walk_done
);

  localparam int CFG_W  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int PIX_W  = COORD_BITS + 1;
  localparam int OUT_DW = ((2 * PIX_W + 7) / 8) * 8;
  localparam int W      = CFG_W + 3;
  localparam int CNT_W  = $clog2(SIZE_BITS + 1);
  localparam int S      = SIZE_BITS;

  // Configuration registers.
  logic                         shape_kind_r;
  logic [S-1:0]                 shape_size_r;
  logic signed [COORD_BITS-1:0] center_x_r;
  logic signed [COORD_BITS-1:0] center_y_r;
  logic [COORD_BITS-1:0]        canvas_width_r;
  logic [COORD_BITS-1:0]        canvas_height_r;

  // Walk state and datapath registers.
  csop_pkg::upc_t  upc_r, upc_nxt;
  csop_pkg::uword_t uw;
  logic                 walking_r;
  logic signed [S:0]    offset_r;
  logic [S-1:0]         k_r;
  logic [2*S-1:0]       rad_r;
  logic [S+1:0]         rem_r;
  logic [S-1:0]         root_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [S-1:0]         fl_r;
  logic                 exact_r;
  logic                 done_r;
  logic signed [W-1:0]  ax_r, ay_r, axf_r, ayf_r;

  logic                 in_acc, out_acc;
  logic [S-1:0]         k_cur;
  logic signed [S+1:0]  f_e, k_e, absf_e, sum_e, dif_e;
  logic                 bad;
  logic [2*S+1:0]       prod;
  logic [S+1:0]         rem_sh, trial;
  logic signed [W-1:0]  ax_c, ay_c, f_w, fl_w;
  logic                 jump;

  assign cfg_ready = 1'b1;
  assign uw        = csop_pkg::ucode_rom(upc_r);
  assign in_tready = uw.in_rdy;
  assign out_tvalid = uw.out_vld;
  assign in_acc    = in_tvalid & uw.in_rdy;
  assign out_acc   = out_tready & uw.out_vld;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_kind_r    <= 1'b0;
      shape_size_r    <= '0;
      center_x_r      <= '0;
      center_y_r      <= '0;
      canvas_width_r  <= COORD_BITS'(64);
      canvas_height_r <= COORD_BITS'(32);
    end else if (cfg_valid) begin
      case (cfg_index)
        csop_pkg::REG_SHAPE_KIND:    shape_kind_r    <= cfg_data[0];
        csop_pkg::REG_SHAPE_SIZE:    shape_size_r    <= cfg_data[S-1:0];
        csop_pkg::REG_CENTER_X:      center_x_r      <= $signed(cfg_data[COORD_BITS-1:0]);
        csop_pkg::REG_CENTER_Y:      center_y_r      <= $signed(cfg_data[COORD_BITS-1:0]);
        csop_pkg::REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_data[COORD_BITS-1:0];
        csop_pkg::REG_CANVAS_HEIGHT: canvas_height_r <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Half extent of the shape from the current registers.
  assign k_cur = shape_kind_r ? {1'b0, shape_size_r[S-1:1]} : shape_size_r;

  // Offset range check and radicand k*k - f*f as (k - |f|) * (k + |f|).
  always_comb begin
    f_e    = {offset_r[S], offset_r};
    k_e    = $signed({2'b00, k_cur});
    bad    = (f_e > k_e) || (f_e < -k_e);
    absf_e = f_e[S+1] ? -f_e : f_e;
    sum_e  = k_e + absf_e;
    dif_e  = k_e - absf_e;
    prod   = {{(S+1){1'b0}}, sum_e[S:0]} * {{(S+1){1'b0}}, dif_e[S:0]};
  end

  // One digit of the square root.
  assign rem_sh = {rem_r[S-1:0], rad_r[2*S-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  // Anchor coordinates of the shape center on the canvas.
  always_comb begin
    ax_c = W'(center_x_r) + $signed(W'(canvas_width_r >> 1)) - W'(1);
    ay_c = W'(center_y_r) + $signed(W'(canvas_height_r >> 1));
    f_w  = W'(offset_r);
    fl_w = shape_kind_r ? $signed(W'(k_r)) : $signed(W'(root_r));
  end

  // Datapath registers, each updated by the operation of the current step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walking_r <= 1'b0;
      offset_r  <= '0;
    end else begin
      case (uw.op)
        csop_pkg::OP_ACCEPT: begin
          if (in_acc && in_tdata[0]) begin
            offset_r  <= -$signed({1'b0, k_cur});
            walking_r <= 1'b1;
          end
        end
        csop_pkg::OP_CHECK: begin
          if (bad) walking_r <= 1'b0;
        end
        csop_pkg::OP_EMIT: begin
          if (out_acc && uw.pt == 2'd3) begin
            if (done_r) begin
              walking_r <= 1'b0;
              offset_r  <= '0;
            end else begin
              offset_r  <= offset_r + (S+1)'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      csop_pkg::OP_CHECK: begin
        k_r    <= k_cur;
        rad_r  <= prod[2*S-1:0];
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(S - 1);
      end
      csop_pkg::OP_ROOT: begin
        rad_r <= {rad_r[2*S-3:0], 2'b00};
        cnt_r <= cnt_r - CNT_W'(1);
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[S-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[S-2:0], 1'b0};
        end
      end
      csop_pkg::OP_PREP: begin
        fl_r    <= fl_w[S-1:0];
        exact_r <= shape_kind_r || (rem_r == '0);
        done_r  <= (offset_r == $signed({1'b0, k_r}));
        ax_r    <= ax_c;
        ay_r    <= ay_c;
        axf_r   <= ax_c + f_w;
        ayf_r   <= ay_c - f_w;
      end
      default: ;
    endcase
  end

  // Sequencer: jump when the word's condition holds, else step on.
  always_comb begin
    case (uw.cond)
      csop_pkg::CND_NO_IN:  jump = !in_acc;
      csop_pkg::CND_SKIP:   jump = !walking_r || bad;
      csop_pkg::CND_MORE:   jump = (cnt_r != '0);
      csop_pkg::CND_NO_OUT: jump = !out_acc;
      default:              jump = 1'b0;
    endcase
    upc_nxt = jump ? uw.target : upc_r + csop_pkg::upc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) upc_r <= '0;
    else        upc_r <= upc_nxt;
  end

  // Point formation: one coordinate is the anchor offset by f, the other the
  // anchor offset by the root (k for a square), truncated toward zero when the root is inexact.
  logic                 side, plus;
  logic signed [W-1:0]  base, raw, adj, col, row, hi_w, lo_w, col_s, row_s;
  logic                 on_c;

  always_comb begin
    side = uw.pt[1];
    plus = uw.pt[1] ^ uw.pt[0];
    base = side ? ax_r : ay_r;
    raw  = plus ? base + $signed(W'(fl_r)) : base - $signed(W'(fl_r));
    adj  = raw;
    if (!exact_r && plus && raw < 0)    adj = raw + W'(1);
    if (!exact_r && !plus && raw > 0)   adj = raw - W'(1);
    col  = side ? adj : axf_r;
    row  = side ? ayf_r : adj;
    hi_w = W'((1 << COORD_BITS) - 1);
    lo_w = -hi_w - W'(1);
    col_s = (col > hi_w) ? hi_w : ((col < lo_w) ? lo_w : col);
    row_s = (row > hi_w) ? hi_w : ((row < lo_w) ? lo_w : row);
    on_c = (col >= 0) && (row >= 0) &&
           (col < $signed(W'(canvas_width_r))) && (row < $signed(W'(canvas_height_r)));
  end

  assign out_tdata = OUT_DW'({row_s[PIX_W-1:0], col_s[PIX_W-1:0]});
  assign out_tlast = (uw.pt == 2'd3);
  assign out_tuser = {done_r && (uw.pt == 2'd3), on_c};

endmodule

// File: sim/circle_square_outline_points_tb.sv
// Self-checking testbench for the circle and square outline point generator.
module circle_square_outline_points_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_BITS      = 8;
  localparam int COORD_BITS     = 11;
  localparam int CFG_BITS       = 11;
  localparam int POINT_BITS     = 24;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_STEPS   = 145;
  localparam int COORD_MAX      = 2047;
  localparam int COORD_MIN      = -2048;

  // One outline point as the block should present it.
  typedef struct packed {
    logic signed [11:0] column;
    logic signed [11:0] row;
    logic               on_canvas;
    logic               last_of_step;
    logic               walk_done;
  } point_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [2:0]            cfg_index;
  logic [CFG_BITS-1:0]   cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;     // restart, zero fill
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [POINT_BITS-1:0] out_tdata;    // pixel_column, pixel_row
  logic                  out_tlast;
  logic [1:0]            out_tuser;    // on_canvas, walk_done

  // Shadow copy of the configuration and the walk state.
  logic       shape_square  = 1'b0;
  int         shape_size    = 0;
  int         center_col    = 0;
  int         center_row    = 0;
  int         canvas_cols   = 64;
  int         canvas_rows   = 32;
  int         walk_offset   = 0;
  logic       walk_active   = 1'b0;

  point_t     expected_points[$];
  int         drawn_steps   = 0;
  int         mismatches    = 0;
  int         quiet_cycles  = 0;
  int         ready_hold    = 0;
  logic       no_idle       = 1'b0;

  circle_square_outline_points #(
    .SIZE_BITS (SIZE_BITS),
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int walk_limit();
    return shape_square ? shape_size / 2 : shape_size;
  endfunction

  // Floor of the square root, one bit at a time from the top.
  function automatic int int_sqrt(input int n);
    int root;
    int b;
    root = 0;
    for (b = 8; b >= 0; b--) begin
      if ((root + (1 << b)) * (root + (1 << b)) <= n) root += (1 << b);
    end
    return root;
  endfunction

  // a + d and a - d truncated toward zero, where d = fl plus a fraction unless exact.
  function automatic int plus_trunc(input int a, input int fl, input logic exact);
    int t;
    t = a + fl;
    return (exact || t >= 0) ? t : t + 1;
  endfunction

  function automatic int minus_trunc(input int a, input int fl, input logic exact);
    int t;
    t = a - fl;
    return (exact || t <= 0) ? t : t - 1;
  endfunction

  function automatic void queue_point(input int col, input int row, input logic last,
                                      input logic done);
    point_t p;
    int     c;
    int     r;
    c = (col > COORD_MAX) ? COORD_MAX : ((col < COORD_MIN) ? COORD_MIN : col);
    r = (row > COORD_MAX) ? COORD_MAX : ((row < COORD_MIN) ? COORD_MIN : row);
    p.column       = c[11:0];
    p.row          = r[11:0];
    p.on_canvas    = (col >= 0 && row >= 0 && col < canvas_cols && row < canvas_rows);
    p.last_of_step = last;
    p.walk_done    = done;
    expected_points.insert(expected_points.size(), p);
  endfunction

  // Work out the four points of one accepted request, if it yields any.
  function automatic void advance_walk(input logic restart);
    int   k;
    int   f;
    int   fl;
    int   ax;
    int   ay;
    logic exact;
    k = walk_limit();
    if (restart) begin
      walk_offset = -k;
      walk_active = 1'b1;
    end
    if (!walk_active) return;
    f = walk_offset;
    // The shape may have shrunk under a running walk.
    if (f < -k || f > k) begin
      walk_active = 1'b0;
      return;
    end
    if (shape_square) begin
      fl    = k;
      exact = 1'b1;
    end else begin
      fl    = int_sqrt(k * k - f * f);
      exact = (fl * fl == k * k - f * f);
    end
    ax = center_col + canvas_cols / 2 - 1;
    ay = center_row + canvas_rows / 2;
    queue_point(ax + f, minus_trunc(ay, fl, exact), 1'b0, 1'b0);
    queue_point(ax + f, plus_trunc(ay, fl, exact), 1'b0, 1'b0);
    queue_point(plus_trunc(ax, fl, exact), ay - f, 1'b0, 1'b0);
    queue_point(minus_trunc(ax, fl, exact), ay - f, 1'b1, f == k);
    drawn_steps++;
    if (f == k) begin
      walk_active = 1'b0;
      walk_offset = 0;
    end else begin
      walk_offset = f + 1;
    end
  endfunction

  // Send one request; valid stays high afterwards so a following request can run on.
  task automatic send_request(input logic restart);
    int g;
    g = random_gap();
    cfg_valid <= 1'b0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_walk(restart);
  endtask

  // Write one register; the caller makes sure the block is idle.
  task automatic write_reg(input logic [2:0] idx, input int value);
    logic [CFG_BITS-1:0] v;
    int                  g;
    v = value[CFG_BITS-1:0];
    g = random_gap();
    in_tvalid <= 1'b0;
    if (g > 0) begin
      cfg_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      csop_pkg::REG_SHAPE_KIND:    shape_square = v[0];
      csop_pkg::REG_SHAPE_SIZE:    shape_size   = int'(v[SIZE_BITS-1:0]);
      csop_pkg::REG_CENTER_X:      center_col   = int'($signed(v));
      csop_pkg::REG_CENTER_Y:      center_row   = int'($signed(v));
      csop_pkg::REG_CANVAS_WIDTH:  canvas_cols  = int'(v);
      csop_pkg::REG_CANVAS_HEIGHT: canvas_rows  = int'(v);
      default: ;
    endcase
  endtask

  // Drop both request lines and wait until every point has come and the block has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(input logic square, input int size, input int cx, input int cy,
                           input int cw, input int ch);
    wait_idle();
    write_reg(csop_pkg::REG_SHAPE_KIND, int'(square));
    write_reg(csop_pkg::REG_SHAPE_SIZE, size);
    write_reg(csop_pkg::REG_CENTER_X, cx);
    write_reg(csop_pkg::REG_CENTER_Y, cy);
    write_reg(csop_pkg::REG_CANVAS_WIDTH, cw);
    write_reg(csop_pkg::REG_CANVAS_HEIGHT, ch);
  endtask

  // Reset settings: an advance with no walk is ignored, then a size 0 circle.
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Empty shapes give a single step at offset 0.
  task automatic test_empty_shapes();
    set_shape(1'b1, 1, 3, -2, 16, 16);
    send_request(1'b1);
    set_shape(1'b1, 0, 0, 0, 16, 16);
    send_request(1'b1);
  endtask

  // Complete walks of a small circle and square without any idling.
  task automatic test_small_walks();
    int i;
    no_idle = 1'b1;
    set_shape(1'b0, 3, 0, 0, 64, 32);
    send_request(1'b1);
    for (i = 0; i < 6; i++) send_request(1'b0);
    set_shape(1'b1, 4, -5, 2, 20, 12);
    send_request(1'b1);
    for (i = 0; i < 4; i++) send_request(1'b0);
    no_idle = 1'b0;
  endtask

  // Largest size, saturated coordinates and an empty canvas.
  task automatic test_extremes();
    set_shape(1'b0, 255, -1024, 1023, 1024, 1024);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    set_shape(1'b1, 255, 1023, 1023, 2047, 2047);
    send_request(1'b1);
    set_shape(1'b0, 7, -1024, -1024, 0, 0);
    send_request(1'b1);
  endtask

  // Shrinking the shape under a running walk ends it without points.
  task automatic test_shrink_mid_walk();
    set_shape(1'b0, 10, 0, 0, 64, 32);
    send_request(1'b1);
    send_request(1'b0);
    wait_idle();
    write_reg(csop_pkg::REG_SHAPE_SIZE, 4);
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // Random shapes, mostly small, walked mostly to the end with some restarts and noise.
  task automatic test_random_walks();
    int start_steps;
    int k;
    int steps;
    int i;
    int r;
    logic first;
    start_steps = drawn_steps;
    first = 1'b1;
    while (drawn_steps - start_steps < RANDOM_STEPS) begin
      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      if (first || $urandom_range(0, 2) == 0) begin
        write_reg(csop_pkg::REG_SHAPE_KIND, $urandom_range(0, 1));
      end
      if (first || $urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 99);
        write_reg(csop_pkg::REG_SHAPE_SIZE, (r < 70) ? $urandom_range(0, 8) :
                  (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 255));
      end
      if (first || $urandom_range(0, 2) == 0) begin
        write_reg(csop_pkg::REG_CENTER_X, ($urandom_range(0, 4) == 0) ?
                  int'($urandom_range(0, 2047)) - 1024 : int'($urandom_range(0, 80)) - 40);
      end
      if (first || $urandom_range(0, 2) == 0) begin
        write_reg(csop_pkg::REG_CENTER_Y, ($urandom_range(0, 4) == 0) ?
                  int'($urandom_range(0, 2047)) - 1024 : int'($urandom_range(0, 80)) - 40);
      end
      if (first || $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        write_reg(csop_pkg::REG_CANVAS_WIDTH, (r < 85) ? $urandom_range(1, 128) :
                  (r < 93) ? $urandom_range(129, 1024) :
                  (r < 97) ? 0 : $urandom_range(1025, 2047));
      end
      if (first || $urandom_range(0, 3) == 0) begin
        r = $urandom_range(0, 99);
        write_reg(csop_pkg::REG_CANVAS_HEIGHT, (r < 85) ? $urandom_range(1, 128) :
                  (r < 93) ? $urandom_range(129, 1024) :
                  (r < 97) ? 0 : $urandom_range(1025, 2047));
      end
      first = 1'b0;
      k = walk_limit();
      steps = (2 * k > 24) ? $urandom_range(1, 24) : 2 * k;
      // Stray advance before the walk starts.
      if ($urandom_range(0, 9) == 0) send_request(1'b0);
      send_request(1'b1);
      for (i = 0; i < steps; i++) send_request($urandom_range(0, 99) < 4);
      // Advances past the end of the walk.
      if ($urandom_range(0, 3) == 0) send_request(1'b0);
    end
    no_idle = 1'b0;
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    int g;
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      g = random_gap();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        ready_hold <= g - 1;
      end
    end
  end

  // Compare every delivered point with the oldest expected one.
  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        $error("point delivered with none expected: column %0d row %0d",
               $signed(out_tdata[11:0]), $signed(out_tdata[23:12]));
        mismatches++;
      end else begin
        exp_pt = expected_points.pop_front();
        if ($signed(out_tdata[11:0]) !== exp_pt.column) begin
          $error("pixel_column: expected %0d, got %0d", exp_pt.column,
                 $signed(out_tdata[11:0]));
          mismatches++;
        end
        if ($signed(out_tdata[23:12]) !== exp_pt.row) begin
          $error("pixel_row: expected %0d, got %0d", exp_pt.row, $signed(out_tdata[23:12]));
          mismatches++;
        end
        if (out_tuser[0] !== exp_pt.on_canvas) begin
          $error("on_canvas: expected %0d, got %0d", exp_pt.on_canvas, out_tuser[0]);
          mismatches++;
        end
        if (out_tlast !== exp_pt.last_of_step) begin
          $error("last_of_step: expected %0d, got %0d", exp_pt.last_of_step, out_tlast);
          mismatches++;
        end
        if (out_tuser[1] !== exp_pt.walk_done) begin
          $error("walk_done: expected %0d, got %0d", exp_pt.walk_done, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no channel has moved anything for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("circle_square_outline_points verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= csop_pkg::REG_SHAPE_KIND;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_empty_shapes();
    test_small_walks();
    test_extremes();
    test_shrink_mid_walk();
    test_random_walks();

    wait_idle();
    if (mismatches == 0) begin
      $display("circle_square_outline_points verification clean");
    end else begin
      $display("circle_square_outline_points verification failed");
    end
    $finish;
  end

endmodule
